FILE: rtl/pbb_pkg.sv
// ----------------------------------------------------------------------------
// Pacing byte budget package
// Shared types, constants and the divide-by-8000 helper for the byte pacer.
// ----------------------------------------------------------------------------
package pbb_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_PACKET = 2'd1,
        FUNC_RATE   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    localparam int WINDOW_W = 14;
    localparam int RATE_W   = 32;
    localparam int MS_W     = 16;
    localparam int SIZE_W   = 16;
    localparam int BUDGET_W = 34;
    localparam int LIMIT_W  = 33;
    localparam int ADD_W    = 36;
    localparam int QUOT_W   = 20;
    localparam int REM_W    = 13;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 14'd500;
    localparam logic [REM_W-1:0]    DIVISOR      = 13'd8000;
    localparam logic [LIMIT_W-1:0]  BUDGET_MAX   = 33'h1_FFFF_FFFF;

    // 8000 = 64 * 125; the divide by 125 uses ceil(2^33 / 125), which is exact
    // for every dividend below 2^26.
    localparam int               PRE_SHIFT   = 6;
    localparam int               RECIP_SHIFT = 33;
    localparam logic [26:0]      RECIP_125   = 27'd68719477;

    // Input item payload.
    typedef struct packed {
        logic [1:0]          func;
        logic [MS_W-1:0]     elapsed_ms;
        logic [SIZE_W-1:0]   packet_bytes;
        logic [RATE_W-1:0]   new_rate_bps;
    } item_t;

    // Result item payload.
    typedef struct packed {
        logic signed [BUDGET_W-1:0] budget_bytes;
        logic                       over_budget;
        logic                       pacing_on;
    } result_t;

    // Precomputed operands handed to the budget update stage.
    typedef struct packed {
        logic [1:0]          func;
        logic                pace_on;
        logic                tick_en;
        logic [SIZE_W-1:0]   size;
        logic [ADD_W-1:0]    add;
        logic [LIMIT_W-1:0]  limit;
    } upd_t;

    // Floor of x / 8000 for any 32-bit x.
    function automatic logic [QUOT_W-1:0] div8000(input logic [RATE_W-1:0] x);
        logic [52:0] prod;
        prod = 53'(x[RATE_W-1:PRE_SHIFT]) * 53'(RECIP_125);
        return prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    endfunction

endpackage

FILE: rtl/pbb_ifs.sv
// ----------------------------------------------------------------------------
// Pacing byte budget channels
// Valid/ready item channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface pbb_item_if;
    logic           valid;
    logic           ready;
    pbb_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pbb_result_if;
    logic             valid;
    logic             ready;
    pbb_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pbb_calc.sv
// ----------------------------------------------------------------------------
// Pacing byte budget operand pipeline
// Tracks the target rate at the input and computes the tick refill and the
// budget limit for every item in a six-stage feed-forward pipeline.
// ----------------------------------------------------------------------------
module pbb_calc (
    input  logic                                clk,
    input  logic                                rst_n,
    pbb_item_if.sink                            item_ch,
    input  logic                                window_we,
    input  logic [pbb_pkg::WINDOW_W-1:0]        window_wdata,
    output logic                                upd_valid,
    input  logic                                upd_ready,
    output pbb_pkg::upd_t                       upd
);

    localparam int NSTG = 6;

    logic [pbb_pkg::WINDOW_W-1:0] window_reg;
    logic [pbb_pkg::RATE_W-1:0]   rate_reg;
    logic [NSTG-1:0]              vld_reg;
    logic [NSTG-1:0]              adv;
    logic                         accept;
    logic [pbb_pkg::RATE_W-1:0]   rate_cur;

    // Stage 1: captured item with the rate that applies after it.
    logic [1:0]                   s1_func_reg;
    logic [pbb_pkg::RATE_W-1:0]   s1_rate_reg;
    logic [pbb_pkg::MS_W-1:0]     s1_ms_reg;
    logic [pbb_pkg::SIZE_W-1:0]   s1_size_reg;
    logic                         s1_pace_reg;
    logic                         s1_tick_reg;

    // Stage 2: quotient of the rate by 8000.
    logic [1:0]                   s2_func_reg;
    logic [pbb_pkg::RATE_W-1:0]   s2_rate_reg;
    logic [pbb_pkg::MS_W-1:0]     s2_ms_reg;
    logic [pbb_pkg::SIZE_W-1:0]   s2_size_reg;
    logic                         s2_pace_reg;
    logic                         s2_tick_reg;
    logic [pbb_pkg::QUOT_W-1:0]   s2_q_reg;

    // Stage 3: remainder of the rate by 8000.
    logic [1:0]                   s3_func_reg;
    logic [pbb_pkg::MS_W-1:0]     s3_ms_reg;
    logic [pbb_pkg::SIZE_W-1:0]   s3_size_reg;
    logic                         s3_pace_reg;
    logic                         s3_tick_reg;
    logic [pbb_pkg::QUOT_W-1:0]   s3_q_reg;
    logic [pbb_pkg::REM_W-1:0]    s3_r_reg;
    logic [32:0]                  q_times_div;

    // Stage 4: partial products.
    logic [1:0]                   s4_func_reg;
    logic [pbb_pkg::SIZE_W-1:0]   s4_size_reg;
    logic                         s4_pace_reg;
    logic                         s4_tick_reg;
    logic [35:0]                  s4_qe_reg;
    logic [33:0]                  s4_qw_reg;
    logic [28:0]                  s4_re_reg;
    logic [26:0]                  s4_rw_reg;

    // Stage 5: remainder products divided by 8000.
    logic [1:0]                   s5_func_reg;
    logic [pbb_pkg::SIZE_W-1:0]   s5_size_reg;
    logic                         s5_pace_reg;
    logic                         s5_tick_reg;
    logic [35:0]                  s5_qe_reg;
    logic [33:0]                  s5_qw_reg;
    logic [16:0]                  s5_req_reg;
    logic [13:0]                  s5_rwq_reg;
    logic [pbb_pkg::QUOT_W-1:0]   re_div;
    logic [pbb_pkg::QUOT_W-1:0]   rw_div;

    // Stage 6: refill and saturated limit.
    pbb_pkg::upd_t                s6_reg;
    logic [34:0]                  lim_sum;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || upd_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign item_ch.ready = adv[0];
    assign accept        = item_ch.valid && adv[0];
    assign upd_valid     = vld_reg[NSTG-1];
    assign upd           = s6_reg;

    // The rate seen by an item is the one in force after it.
    assign rate_cur = (item_ch.data.func == pbb_pkg::FUNC_RATE) ?
                      item_ch.data.new_rate_bps : rate_reg;

    // Control: window register, tracked rate and stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= pbb_pkg::WINDOW_RESET;
            rate_reg   <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            if (window_we)
            begin
                window_reg <= window_wdata;
            end
            if (accept)
            begin
                rate_reg <= rate_cur;
            end
            if (adv[0])
            begin
                vld_reg[0] <= item_ch.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Combinational helpers between stages.
    assign q_times_div = 33'(s2_q_reg) * 33'(pbb_pkg::DIVISOR);
    assign re_div      = pbb_pkg::div8000(32'(s4_re_reg));
    assign rw_div      = pbb_pkg::div8000(32'(s4_rw_reg));
    assign lim_sum     = 35'(s5_qw_reg) + 35'(s5_rwq_reg);

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_func_reg <= item_ch.data.func;
            s1_rate_reg <= rate_cur;
            s1_ms_reg   <= item_ch.data.elapsed_ms;
            s1_size_reg <= item_ch.data.packet_bytes;
            s1_pace_reg <= (rate_cur != '0);
            s1_tick_reg <= (rate_cur != '0) && (item_ch.data.elapsed_ms != '0);
        end
        if (adv[1])
        begin
            s2_func_reg <= s1_func_reg;
            s2_rate_reg <= s1_rate_reg;
            s2_ms_reg   <= s1_ms_reg;
            s2_size_reg <= s1_size_reg;
            s2_pace_reg <= s1_pace_reg;
            s2_tick_reg <= s1_tick_reg;
            s2_q_reg    <= pbb_pkg::div8000(s1_rate_reg);
        end
        if (adv[2])
        begin
            s3_func_reg <= s2_func_reg;
            s3_ms_reg   <= s2_ms_reg;
            s3_size_reg <= s2_size_reg;
            s3_pace_reg <= s2_pace_reg;
            s3_tick_reg <= s2_tick_reg;
            s3_q_reg    <= s2_q_reg;
            s3_r_reg    <= s2_rate_reg[pbb_pkg::REM_W-1:0] -
                           q_times_div[pbb_pkg::REM_W-1:0];
        end
        if (adv[3])
        begin
            s4_func_reg <= s3_func_reg;
            s4_size_reg <= s3_size_reg;
            s4_pace_reg <= s3_pace_reg;
            s4_tick_reg <= s3_tick_reg;
            s4_qe_reg   <= 36'(s3_q_reg) * 36'(s3_ms_reg);
            s4_qw_reg   <= 34'(s3_q_reg) * 34'(window_reg);
            s4_re_reg   <= 29'(s3_r_reg) * 29'(s3_ms_reg);
            s4_rw_reg   <= 27'(s3_r_reg) * 27'(window_reg);
        end
        if (adv[4])
        begin
            s5_func_reg <= s4_func_reg;
            s5_size_reg <= s4_size_reg;
            s5_pace_reg <= s4_pace_reg;
            s5_tick_reg <= s4_tick_reg;
            s5_qe_reg   <= s4_qe_reg;
            s5_qw_reg   <= s4_qw_reg;
            s5_req_reg  <= re_div[16:0];
            s5_rwq_reg  <= rw_div[13:0];
        end
        if (adv[5])
        begin
            s6_reg.func    <= s5_func_reg;
            s6_reg.pace_on <= s5_pace_reg;
            s6_reg.tick_en <= s5_tick_reg;
            s6_reg.size    <= s5_size_reg;
            s6_reg.add     <= s5_qe_reg + 36'(s5_req_reg);
            s6_reg.limit   <= (lim_sum > 35'(pbb_pkg::BUDGET_MAX)) ?
                              pbb_pkg::BUDGET_MAX : lim_sum[pbb_pkg::LIMIT_W-1:0];
        end
    end

endmodule

FILE: rtl/pbb_budget.sv
// ----------------------------------------------------------------------------
// Pacing byte budget update
// Holds the signed byte budget, applies one item per cycle unless the result
// channel stalls, and drives the result register.
// ----------------------------------------------------------------------------
module pbb_budget (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           upd_valid,
    output logic           upd_ready,
    input  pbb_pkg::upd_t  upd,
    pbb_result_if.source   result_ch
);

    logic signed [pbb_pkg::BUDGET_W-1:0] budget_reg;
    logic signed [pbb_pkg::BUDGET_W-1:0] budget_next;
    logic                                res_valid_reg;
    pbb_pkg::result_t                    res_reg;
    logic                                over_next;
    logic                                take;

    logic signed [37:0] b;
    logic signed [37:0] addx;
    logic signed [37:0] limx;
    logic signed [37:0] sizex;
    logic signed [37:0] refill;
    logic signed [37:0] diff;
    logic signed [37:0] nb;

    assign upd_ready = !res_valid_reg || result_ch.ready;
    assign take      = upd_valid && upd_ready;

    assign result_ch.valid = res_valid_reg;
    assign result_ch.data  = res_reg;

    // Operands widened to a common signed width.
    assign b      = 38'(budget_reg);
    assign addx   = $signed({2'b00, upd.add});
    assign limx   = $signed({5'b00000, upd.limit});
    assign sizex  = $signed({22'd0, upd.size});
    assign refill = b[37] ? (b + addx) : addx;
    assign diff   = b - sizex;

    // Budget update for the item in hand.
    always_comb
    begin
        nb        = b;
        over_next = 1'b0;
        case (upd.func)
            pbb_pkg::FUNC_TICK:
            begin
                if (upd.tick_en)
                begin
                    nb = (refill < limx) ? refill : limx;
                end
            end
            pbb_pkg::FUNC_PACKET:
            begin
                if (upd.pace_on)
                begin
                    if (b >= sizex)
                    begin
                        nb = diff;
                    end
                    else
                    begin
                        nb        = (diff > -limx) ? diff : -limx;
                        over_next = 1'b1;
                    end
                end
            end
            pbb_pkg::FUNC_RATE:
            begin
                if (!upd.pace_on)
                begin
                    nb = '0;
                end
                else if (b > limx)
                begin
                    nb = limx;
                end
                else if (b < -limx)
                begin
                    nb = -limx;
                end
            end
            default:
            begin
                nb = b;
            end
        endcase
        budget_next = nb[pbb_pkg::BUDGET_W-1:0];
    end

    // Budget state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                budget_reg <= budget_next;
            end
            if (upd_ready)
            begin
                res_valid_reg <= upd_valid;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg.budget_bytes <= budget_next;
            res_reg.over_budget  <= over_next;
            res_reg.pacing_on    <= upd.pace_on;
        end
    end

endmodule

FILE: rtl/pacing_byte_budget.sv
// Structure: an accepted item passes the operand stages, then the budget update registers its result.
// Throughput: one item per cycle unless the result channel stalls; six operand stages feed the budget update.
// Back-pressure on the result channel stalls the pipeline stage by stage.
// Reset: window_ms is 500, the budget is zero and pacing is off.
// ----------------------------------------------------------------------------
// Pacing byte budget top level
// Signed byte budget for a packet pacer with tick refill and rate changes.
// ----------------------------------------------------------------------------
module pacing_byte_budget (
    input  logic                          clk,
    input  logic                          rst_n,
    pbb_item_if.sink                      item_ch,
    pbb_result_if.source                  result_ch,
    input  logic                          window_we,
    input  logic [pbb_pkg::WINDOW_W-1:0]  window_wdata
);

    logic          upd_valid;
    logic          upd_ready;
    pbb_pkg::upd_t upd;

    // Operand pipeline.
    pbb_calc u_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ch      (item_ch),
        .window_we    (window_we),
        .window_wdata (window_wdata),
        .upd_valid    (upd_valid),
        .upd_ready    (upd_ready),
        .upd          (upd)
    );

    // Budget state and result register.
    pbb_budget u_budget (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd_valid),
        .upd_ready (upd_ready),
        .upd       (upd),
        .result_ch (result_ch)
    );

endmodule
